// ----- rtl/chbd_pkg.sv -----
// Shared types and constants for the chunked body decoder.
package chbd_pkg;

   localparam int SIZE_BITS_DEFAULT   = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   // End status codes carried with a stream_done result.
   localparam logic [1:0] END_COMPLETE  = 2'd0;
   localparam logic [1:0] END_NO_DIGITS = 2'd1;
   localparam logic [1:0] END_EARLY     = 2'd2;

   // One classified input transfer as it travels through the queue.
   typedef struct packed {
      logic       source_end;
      logic [7:0] body_byte;
      logic       is_hex;
      logic [3:0] hex_val;
      logic       is_lf;
      logic       is_cr;
   } item_type;

endpackage

// ----- rtl/chbd_front.sv -----
// Front end: accepts raw body bytes and classifies them for the parser.
module chbd_front (
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_body_byte,
   input  logic              req_source_end,
   output logic              push_valid,
   input  logic              push_ready,
   output chbd_pkg::item_type push_item
);

   logic       is_hex;
   logic [3:0] hex_val;

   always_comb begin
      is_hex  = 1'b0;
      hex_val = 4'd0;
      if (req_body_byte >= 8'h30 && req_body_byte <= 8'h39) begin
         is_hex  = 1'b1;
         hex_val = 4'(req_body_byte - 8'h30);
      end else if (req_body_byte >= 8'h61 && req_body_byte <= 8'h66) begin
         is_hex  = 1'b1;
         hex_val = 4'(req_body_byte - 8'h57);
      end else if (req_body_byte >= 8'h41 && req_body_byte <= 8'h46) begin
         is_hex  = 1'b1;
         hex_val = 4'(req_body_byte - 8'h37);
      end
   end

   assign push_valid           = req_valid;
   assign req_stall            = !push_ready;
   assign push_item.source_end = req_source_end;
   assign push_item.body_byte  = req_body_byte;
   assign push_item.is_hex     = is_hex;
   assign push_item.hex_val    = hex_val;
   assign push_item.is_lf      = (req_body_byte == chbd_pkg::CHAR_LF);
   assign push_item.is_cr      = (req_body_byte == chbd_pkg::CHAR_CR);

endmodule

// ----- rtl/chbd_queue.sv -----
// Short FIFO of classified items between the front end and the parser.
module chbd_queue #(
   parameter int DEPTH = chbd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  chbd_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output chbd_pkg::item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   chbd_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy exceeds its depth");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue occupancy did not grow on a lone push");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with diverged pointers");

endmodule

// ----- rtl/chbd_back.sv -----
// Back end: chunk framing state machine and the registered result stage.
module chbd_back #(
   parameter int SIZE_BITS = chbd_pkg::SIZE_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  chbd_pkg::item_type pop_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_payload_byte,
   output logic               rsp_chunk_last,
   output logic               rsp_stream_done,
   output logic [1:0]         rsp_end_status
);

   typedef enum logic [4:0] {
      MODE_SIZE    = 5'b00001,
      MODE_DATA    = 5'b00010,
      MODE_SKIP    = 5'b00100,
      MODE_TRAILER = 5'b01000,
      MODE_DONE    = 5'b10000
   } mode_type;

   mode_type             mode_ff, mode_in;
   logic [SIZE_BITS-1:0] remaining_ff, remaining_in;
   logic                 digits_seen_ff, digits_seen_in;
   logic                 digits_stopped_ff, digits_stopped_in;
   logic [1:0]           line_count_ff, line_count_in;
   logic                 last_cr_ff, last_cr_in;
   logic                 skip_one_ff, skip_one_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           payload_ff, payload_in;
   logic                 last_ff, last_in;
   logic                 done_ff, done_in;
   logic [1:0]           status_ff, status_in;

   logic                 take;
   logic                 emit;
   logic                 finish;
   logic [1:0]           finish_status;
   logic                 on_last;

   assign pop_ready = !rsp_valid_ff || !rsp_stall;
   assign take      = pop_valid && pop_ready;
   assign on_last   = (remaining_ff == SIZE_BITS'(1));

   always_comb begin
      mode_in           = mode_ff;
      remaining_in      = remaining_ff;
      digits_seen_in    = digits_seen_ff;
      digits_stopped_in = digits_stopped_ff;
      line_count_in     = line_count_ff;
      last_cr_in        = last_cr_ff;
      skip_one_in       = skip_one_ff;
      emit              = 1'b0;
      finish            = 1'b0;
      finish_status     = chbd_pkg::END_COMPLETE;

      if (take && mode_ff != MODE_DONE) begin
         if (pop_item.source_end) begin
            finish        = 1'b1;
            finish_status = chbd_pkg::END_EARLY;
         end else begin
            unique case (mode_ff)
               MODE_SIZE: begin
                  if (pop_item.is_lf) begin
                     if (!digits_seen_ff) begin
                        finish        = 1'b1;
                        finish_status = chbd_pkg::END_NO_DIGITS;
                     end else if (remaining_ff == '0) begin
                        mode_in       = MODE_TRAILER;
                        line_count_in = 2'd0;
                        last_cr_in    = 1'b0;
                     end else begin
                        mode_in = MODE_DATA;
                     end
                  end else if (!digits_stopped_ff) begin
                     if (pop_item.is_hex) begin
                        remaining_in   = {remaining_ff[SIZE_BITS-5:0], pop_item.hex_val};
                        digits_seen_in = 1'b1;
                     end else begin
                        digits_stopped_in = 1'b1;
                     end
                  end
               end
               MODE_DATA: begin
                  remaining_in = remaining_ff - 1'b1;
                  emit         = 1'b1;
                  if (on_last) begin
                     mode_in     = MODE_SKIP;
                     skip_one_in = 1'b0;
                  end
               end
               MODE_SKIP: begin
                  if (!skip_one_ff) begin
                     skip_one_in = 1'b1;
                  end else begin
                     skip_one_in       = 1'b0;
                     mode_in           = MODE_SIZE;
                     remaining_in      = '0;
                     digits_seen_in    = 1'b0;
                     digits_stopped_in = 1'b0;
                  end
               end
               MODE_TRAILER: begin
                  if (pop_item.is_lf) begin
                     if (line_count_ff == 2'd0 || (line_count_ff == 2'd1 && last_cr_ff)) begin
                        finish        = 1'b1;
                        finish_status = chbd_pkg::END_COMPLETE;
                     end else begin
                        line_count_in = 2'd0;
                        last_cr_in    = 1'b0;
                     end
                  end else begin
                     if (line_count_ff != 2'd2) begin
                        line_count_in = line_count_ff + 1'b1;
                     end
                     last_cr_in = pop_item.is_cr;
                  end
               end
               default: begin
                  mode_in = MODE_DONE;
               end
            endcase
         end
      end

      if (finish) begin
         mode_in = MODE_DONE;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      payload_in   = payload_ff;
      last_in      = last_ff;
      done_in      = done_ff;
      status_in    = status_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         payload_in   = pop_item.body_byte;
         last_in      = on_last;
         done_in      = 1'b0;
         status_in    = chbd_pkg::END_COMPLETE;
      end else if (finish) begin
         rsp_valid_in = 1'b1;
         payload_in   = 8'd0;
         last_in      = 1'b0;
         done_in      = 1'b1;
         status_in    = finish_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_SIZE;
         remaining_ff      <= '0;
         digits_seen_ff    <= 1'b0;
         digits_stopped_ff <= 1'b0;
         line_count_ff     <= 2'd0;
         last_cr_ff        <= 1'b0;
         skip_one_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         mode_ff           <= mode_in;
         remaining_ff      <= remaining_in;
         digits_seen_ff    <= digits_seen_in;
         digits_stopped_ff <= digits_stopped_in;
         line_count_ff     <= line_count_in;
         last_cr_ff        <= last_cr_in;
         skip_one_ff       <= skip_one_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      last_ff    <= last_in;
      done_ff    <= done_in;
      status_ff  <= status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload_byte = payload_ff;
   assign rsp_chunk_last   = last_ff;
   assign rsp_stream_done  = done_ff;
   assign rsp_end_status   = status_ff;

   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_DATA) |-> (remaining_ff != '0))
      else $error("payload mode entered with nothing left to pass");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> (payload_ff == 8'd0 && !last_ff))
      else $error("end result carries payload");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !done_ff) |-> (status_ff == chbd_pkg::END_COMPLETE))
      else $error("payload result carries an end status");
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_DONE) |=> (mode_ff == MODE_DONE))
      else $error("parser left the finished state");

endmodule

// ----- rtl/http_chunked_body_decoder_unit.sv -----
// Top level of the chunked body decoder: front end, item queue and parser.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   req_body_byte, req_source_end
//   rsp      out        rsp_valid/rsp_stall   rsp_payload_byte, rsp_chunk_last,
//                                             rsp_stream_done, rsp_end_status
//
// One input transfer is taken every cycle while the queue has room, and the
// parser retires one queued byte per cycle while rsp_stall is low, so the
// sustained rate is one byte per clock. On its way out a transfer is held in
// a queue entry, and the result it causes is held in the result register.
// Reset is synchronous and active high; it clears the queue, the parser state
// and the result valid flag, and the block takes transfers in the next cycle.
// rsp_stall holds the result register and stops the parser; req_stall rises
// only once the queue is full, so the two sides stall independently.
module http_chunked_body_decoder_unit #(
   parameter int SIZE_BITS   = chbd_pkg::SIZE_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = chbd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_body_byte,
   input  logic       req_source_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_chunk_last,
   output logic       rsp_stream_done,
   output logic [1:0] rsp_end_status
);

   // Classified items travelling from the front end into the queue.
   chbd_pkg::item_type push_item;
   logic               push_valid;
   logic               push_ready;

   // Items leaving the queue towards the parser.
   chbd_pkg::item_type pop_item;
   logic               pop_valid;
   logic               pop_ready;

   // The front end decodes hex digits and line-end characters once, so the
   // parser sees ready-made flags rather than raw byte compares.
   chbd_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_body_byte  (req_body_byte),
      .req_source_end (req_source_end),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_item      (push_item)
   );

   // The queue absorbs a stalled result channel for up to QUEUE_DEPTH transfers
   // before back-pressure reaches the source.
   chbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // The parser walks size lines, payload, the two separator bytes and the
   // trailer, and produces at most one result per byte it consumes.
   chbd_back #(
      .SIZE_BITS (SIZE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_item         (pop_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_chunk_last   (rsp_chunk_last),
      .rsp_stream_done  (rsp_stream_done),
      .rsp_end_status   (rsp_end_status)
   );

endmodule
